/* rtl/worker_registry_with_aging_assert.svh */
// Assertion macros for the worker registry.
// Included by the top level; depends on nothing else.
`ifndef WORKER_REGISTRY_WITH_AGING_ASSERT_SVH
`define WORKER_REGISTRY_WITH_AGING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wrwa_pkg.sv */
// Shared constants, codes and control structs for the worker registry.
// No dependencies; the design and interface files use it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package wrwa_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 48;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam int COMMAND_W = 2;
    localparam int KEY_W     = 48;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int GRANTED_W = 5;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_REGISTER = 2'd0,
        CMD_REQUEST  = 2'd1,
        CMD_SWEEP    = 2'd2
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED     = 3'd0,
        ST_STORED        = 3'd1,
        ST_FULL          = 3'd2,
        ST_BAD_COUNT     = 3'd3,
        ST_GRANT_HEADER  = 3'd4,
        ST_GRANTED_ENTRY = 3'd5,
        ST_SWEEP_DONE    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GRANT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic grant_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [COMMAND_W-1:0] command;
        logic                 out_free;
        logic                 grant_nz;
        logic                 remain_one;
        logic                 any_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/wrwa_in_if.sv */
// Command channel interface: valid, ready and the command payload.
// Depends on wrwa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wrwa_in_if;
    logic                           valid;
    logic                           ready;
    logic [wrwa_pkg::COMMAND_W-1:0] command;
    logic [wrwa_pkg::KEY_W-1:0]     key;
    logic [wrwa_pkg::COUNT_W-1:0]   count;

    modport source (output valid, command, key, count, input ready);
    modport sink   (input valid, command, key, count, output ready);
endinterface

`default_nettype wire

/* rtl/wrwa_out_if.sv */
// Result channel interface: valid, ready and the result payload.
// Depends on wrwa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wrwa_out_if;
    logic                           valid;
    logic                           ready;
    logic [wrwa_pkg::STATUS_W-1:0]  status;
    logic [wrwa_pkg::KEY_W-1:0]     key_res;
    logic [wrwa_pkg::GRANTED_W-1:0] granted;
    logic                           last;

    modport source (output valid, status, key_res, granted, last, input ready);
    modport sink   (input valid, status, key_res, granted, last, output ready);
endinterface

`default_nettype wire

/* rtl/wrwa_ctrl.sv */
// Sequencer for the worker registry: accept, execute, grant loop.
// Depends on wrwa_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module wrwa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wrwa_pkg::t_dp_stat      i_stat,
    output wrwa_pkg::t_dp_cmd       o_cmd
);

    wrwa_pkg::t_state r_state;
    wrwa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrwa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrwa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = wrwa_pkg::S_EXEC;
                end
            end
            wrwa_pkg::S_EXEC: begin
                case (i_stat.command) inside
                    wrwa_pkg::CMD_REGISTER, wrwa_pkg::CMD_SWEEP: begin
                        if (i_stat.out_free) begin
                            n_state = wrwa_pkg::S_IDLE;
                        end
                    end
                    wrwa_pkg::CMD_REQUEST: begin
                        if (i_stat.out_free) begin
                            n_state = i_stat.grant_nz ? wrwa_pkg::S_GRANT : wrwa_pkg::S_IDLE;
                        end
                    end
                    default: n_state = wrwa_pkg::S_IDLE;  // unused code: drop it
                endcase
            end
            wrwa_pkg::S_GRANT: begin
                if (i_stat.out_free && i_stat.remain_one) begin
                    n_state = wrwa_pkg::S_IDLE;
                end
            end
            default: n_state = wrwa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.grant_step = 1'b0;
        unique case (r_state)
            wrwa_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_rst_n && i_in_valid;
            end
            wrwa_pkg::S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            wrwa_pkg::S_GRANT: begin
                o_cmd.grant_step = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/wrwa_dp.sv */
// Datapath of the worker registry: key table, valid/alive marks, match, result register.
// Depends on wrwa_pkg; commanded by wrwa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module wrwa_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wrwa_pkg::t_dp_cmd                   i_cmd,
    output wrwa_pkg::t_dp_stat                  o_stat,
    input  wire logic [wrwa_pkg::COMMAND_W-1:0] i_command,
    input  wire logic [wrwa_pkg::KEY_W-1:0]     i_key,
    input  wire logic [wrwa_pkg::COUNT_W-1:0]   i_count,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [wrwa_pkg::STATUS_W-1:0]       o_status,
    output logic [wrwa_pkg::KEY_W-1:0]          o_key_res,
    output logic [wrwa_pkg::GRANTED_W-1:0]      o_granted,
    output logic                                o_last
);

    // table
    logic [wrwa_pkg::ENTRIES-1:0]  r_valid;
    logic [wrwa_pkg::ENTRIES-1:0]  r_alive;
    logic [wrwa_pkg::KEY_BITS-1:0] r_key [wrwa_pkg::ENTRIES];
    logic [wrwa_pkg::ENTRIES-1:0]  n_valid;
    logic [wrwa_pkg::ENTRIES-1:0]  n_alive;
    logic                          key_we;

    // captured command and lookup results
    logic [wrwa_pkg::COMMAND_W-1:0] r_cmd;
    logic [wrwa_pkg::COUNT_W-1:0]   r_count;
    logic [wrwa_pkg::KEY_BITS-1:0]  r_key_in;
    logic [wrwa_pkg::ENTRIES-1:0]   r_match;
    logic                           r_hit;
    logic                           r_free_any;
    logic [wrwa_pkg::IDX_W-1:0]     r_free_idx;
    logic [wrwa_pkg::CNT_W-1:0]     r_avail;
    logic [wrwa_pkg::CNT_W-1:0]     r_remain;
    logic [wrwa_pkg::CNT_W-1:0]     n_remain;

    // result register
    logic                           r_out_valid;
    logic [wrwa_pkg::STATUS_W-1:0]  r_status;
    logic [wrwa_pkg::KEY_W-1:0]     r_key_res;
    logic [wrwa_pkg::GRANTED_W-1:0] r_granted;
    logic                           r_last;
    logic                           n_out_valid;
    logic [wrwa_pkg::STATUS_W-1:0]  n_status;
    logic [wrwa_pkg::KEY_W-1:0]     n_key_res;
    logic [wrwa_pkg::GRANTED_W-1:0] n_granted;
    logic                           n_last;

    logic [wrwa_pkg::ENTRIES-1:0]   match;
    logic [wrwa_pkg::IDX_W-1:0]     free_idx;
    logic [wrwa_pkg::IDX_W-1:0]     low_idx;
    logic [wrwa_pkg::CNT_W-1:0]     grant;
    logic                           out_free;

    // Parallel match against the incoming key, among valid slots only.
    always_comb begin
        for (int i = 0; i < wrwa_pkg::ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == wrwa_pkg::KEY_BITS'(i_key));
        end
    end

    // Highest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = 0; i < wrwa_pkg::ENTRIES; i++) begin
            if (!r_valid[i]) begin
                free_idx = wrwa_pkg::IDX_W'(i);
            end
        end
    end

    // Lowest valid slot, next to grant.
    always_comb begin
        low_idx = '0;
        for (int i = wrwa_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i]) begin
                low_idx = wrwa_pkg::IDX_W'(i);
            end
        end
    end

    assign grant    = (wrwa_pkg::COUNT_W'(r_avail) < r_count) ? r_avail
                                                             : wrwa_pkg::CNT_W'(r_count);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_valid     = r_valid;
        n_alive     = r_alive;
        key_we      = 1'b0;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_key_res   = r_key_res;
        n_granted   = r_granted;
        n_last      = r_last;

        if (i_cmd.exec) begin
            n_key_res = '0;
            n_granted = '0;
            n_last    = 1'b1;
            case (r_cmd)
                wrwa_pkg::CMD_REGISTER: begin
                    n_out_valid = 1'b1;
                    if (r_hit) begin
                        n_alive  = r_alive | r_match;
                        n_status = wrwa_pkg::ST_REFRESHED;
                    end else if (r_free_any) begin
                        n_valid[r_free_idx] = 1'b1;
                        n_alive[r_free_idx] = 1'b1;
                        key_we              = 1'b1;
                        n_status            = wrwa_pkg::ST_STORED;
                    end else begin
                        n_status = wrwa_pkg::ST_FULL;
                    end
                end
                wrwa_pkg::CMD_REQUEST: begin
                    n_out_valid = 1'b1;
                    if (r_count == '0) begin
                        n_status = wrwa_pkg::ST_BAD_COUNT;
                    end else begin
                        n_status  = wrwa_pkg::ST_GRANT_HEADER;
                        n_granted = wrwa_pkg::GRANTED_W'(grant);
                        n_last    = (grant == '0);
                        n_remain  = grant;
                    end
                end
                wrwa_pkg::CMD_SWEEP: begin
                    n_out_valid = 1'b1;
                    n_valid     = r_valid & r_alive;
                    n_alive     = '0;
                    n_status    = wrwa_pkg::ST_SWEEP_DONE;
                end
                default: begin
                    n_out_valid = r_out_valid && !i_out_ready;
                end
            endcase
        end else if (i_cmd.grant_step) begin
            n_out_valid      = 1'b1;
            n_status         = wrwa_pkg::ST_GRANTED_ENTRY;
            n_key_res        = wrwa_pkg::KEY_W'(r_key[low_idx]);
            n_granted        = '0;
            n_last           = (r_remain == wrwa_pkg::CNT_W'(1));
            n_valid[low_idx] = 1'b0;
            n_remain         = r_remain - wrwa_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_alive     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_alive     <= n_alive;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_count    <= i_count;
            r_key_in   <= wrwa_pkg::KEY_BITS'(i_key);
            r_match    <= match;
            r_hit      <= |match;
            r_free_any <= ~&r_valid;
            r_free_idx <= free_idx;
            r_avail    <= wrwa_pkg::CNT_W'($countones(r_valid));
        end
        if (key_we) begin
            r_key[r_free_idx] <= r_key_in;
        end
        r_status  <= n_status;
        r_key_res <= n_key_res;
        r_granted <= n_granted;
        r_last    <= n_last;
    end

    assign o_stat.command    = r_cmd;
    assign o_stat.out_free   = out_free;
    assign o_stat.grant_nz   = (r_count != '0) && (r_avail != '0);
    assign o_stat.remain_one = (r_remain == wrwa_pkg::CNT_W'(1));
    assign o_stat.any_valid  = |r_valid;

    assign o_out_valid = r_out_valid && i_rst_n;
    assign o_status    = r_status;
    assign o_key_res   = r_key_res;
    assign o_granted   = r_granted;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* rtl/worker_registry_with_aging.sv */
// Top level of the worker registry with liveness aging.
// Depends on wrwa_pkg, wrwa_in_if, wrwa_out_if, wrwa_ctrl, wrwa_dp and the assertion header.
//
//   Channel   Dir   Payload                              Transactions per command
//   i_in      in    command, key, count                  one
//   o_out     out   status, key_res, granted, last       0 to 17 (none for code 3), last marks the final one
//
// Register and sweep first capture the command and run the parallel key match, then update the
// table and load the result register. A request does the same and then hands out its granted
// keys, one key per cycle while the result channel is ready, from the lowest valid slot. Command
// code 3 produces nothing. Reset (synchronous) clears the valid and alive marks at once; no sweep
// follows. A stalled result holds the sequencer, but a new command is taken while the last
// result of the previous one still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "worker_registry_with_aging_assert.svh"

module worker_registry_with_aging (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wrwa_in_if.sink     i_in,
    wrwa_out_if.source  o_out
);

    wrwa_pkg::t_dp_cmd  dp_cmd;
    wrwa_pkg::t_dp_stat dp_stat;
    logic               in_ready;

    // Sequencer: owns the handshake on the command side and paces the grant loop.
    wrwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Table, match logic and the result register that parts the two channels.
    wrwa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_command   (i_in.command),
        .i_key       (i_in.key),
        .i_count     (i_in.count),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_key_res   (o_out.key_res),
        .o_granted   (o_out.granted),
        .o_last      (o_out.last)
    );

    assign i_in.ready = in_ready;

    // One command in flight: a transaction is never followed by another in the next cycle.
    `WRWA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && in_ready, !in_ready, "command accepted while previous one in flight")

    // The sequencer never pushes a result into an occupied result register.
    `WRWA_ASSERT_NOW(a_grant_has_room, i_clk, i_rst_n, dp_cmd.grant_step || dp_cmd.exec, dp_stat.out_free, "result pushed into a full output register")

    // Every grant step finds a valid slot to hand out.
    `WRWA_ASSERT_NOW(a_grant_has_entry, i_clk, i_rst_n, dp_cmd.grant_step, dp_stat.any_valid, "grant step with an empty table")

endmodule

`default_nettype wire

/* test/tb_worker_registry_with_aging.sv */
`timescale 1ns / 1ps
// Self-checking testbench for worker_registry_with_aging: directed and random commands,
// results predicted by a table model kept here. Depends on wrwa_pkg, wrwa_in_if and wrwa_out_if.
module tb_worker_registry_with_aging;
    import wrwa_pkg::*;

    // Unused command code: the block must drop it without a result.
    localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 7;
    localparam int GAP_MAX     = 12;
    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_CMDS = 154;
    localparam int HOLD_AT     = 80;
    localparam int HOLD_CYC    = 200;
    localparam int DRAIN_CYC   = 20;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [COMMAND_W-1:0] command;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   count;
        int                   gap;
        bit                   drain;
    } reg_cmd_t;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     key_res;
        logic [GRANTED_W-1:0] granted;
        logic                 last;
    } reg_result_t;

    logic i_clk;
    logic i_rst_n;

    wrwa_in_if  in_ch();
    wrwa_out_if out_ch();

    worker_registry_with_aging DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow of the registry table.
    bit               slot_valid [ENTRIES];
    bit               slot_alive [ENTRIES];
    logic [KEY_W-1:0] slot_key   [ENTRIES];

    reg_cmd_t    cmd_queue[$];
    reg_result_t expected_results[$];

    logic [KEY_W-1:0] worker_pool [POOL_SIZE];
    bit               gen_burst;
    int               cmds_total;
    int               cmds_accepted;
    int               fail_count;

    // Driver locals.
    bit       tx_accept;
    int       tx_idle;
    int       tx_idle_eff;
    reg_cmd_t tx_item;

    // Receiver locals.
    int rx_gap;
    int rx_draw;
    int rx_taken;
    int hold_left;
    bit hold_done;

    int          stall_cycles;
    reg_result_t mon_exp;

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    // Queue a command; its idle gap is drawn now, zero inside a burst stretch.
    function automatic void add_cmd(logic [COMMAND_W-1:0] cmd, logic [KEY_W-1:0] k,
                                    logic [COUNT_W-1:0] cnt, bit drain);
        reg_cmd_t c;
        c.command = cmd;
        c.key     = k;
        c.count   = cnt;
        c.gap     = gen_burst ? 0 : $urandom_range(0, GAP_MAX);
        c.drain   = drain;
        cmd_queue.push_back(c);
    endfunction

    function automatic void push_result(t_status st, logic [KEY_W-1:0] k,
                                        logic [GRANTED_W-1:0] gr, logic lst);
        reg_result_t r;
        r.status  = st;
        r.key_res = k;
        r.granted = gr;
        r.last    = lst;
        expected_results.push_back(r);
    endfunction

    // Update the shadow table for one accepted command and queue what it should emit.
    function automatic void apply_command(logic [COMMAND_W-1:0] cmd, logic [KEY_W-1:0] k,
                                          logic [COUNT_W-1:0] cnt);
        int free_slot;
        bit hit;
        int avail;
        int grant;
        free_slot = -1;
        hit       = 0;
        avail     = 0;
        case (cmd)
            CMD_REGISTER: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit) begin
                        // keep the first match only
                    end else if (!slot_valid[i]) begin
                        free_slot = i;
                    end else if (slot_key[i] == k) begin
                        slot_alive[i] = 1;
                        hit = 1;
                    end
                end
                if (hit) begin
                    push_result(ST_REFRESHED, '0, '0, 1'b1);
                end else if (free_slot < 0) begin
                    push_result(ST_FULL, '0, '0, 1'b1);
                end else begin
                    slot_valid[free_slot] = 1;
                    slot_alive[free_slot] = 1;
                    slot_key[free_slot]   = k;
                    push_result(ST_STORED, '0, '0, 1'b1);
                end
            end
            CMD_REQUEST: begin
                if (cnt == 0) begin
                    push_result(ST_BAD_COUNT, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_valid[i]) avail++;
                    end
                    grant = (int'(cnt) < avail) ? int'(cnt) : avail;
                    push_result(ST_GRANT_HEADER, '0, GRANTED_W'(grant), grant == 0);
                    // Grant in ascending slot order, removing each one; alive is untouched.
                    for (int i = 0; i < ENTRIES && grant > 0; i++) begin
                        if (slot_valid[i]) begin
                            grant--;
                            push_result(ST_GRANTED_ENTRY, slot_key[i], '0, grant == 0);
                            slot_valid[i] = 0;
                        end
                    end
                end
            end
            CMD_SWEEP: begin
                // Age every slot, valid or not: alive drops, no alive means the entry goes.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_alive[i]) slot_alive[i] = 0;
                    else slot_valid[i] = 0;
                end
                push_result(ST_SWEEP_DONE, '0, '0, 1'b1);
            end
            default: begin
                // unused code: no state change, no result
            end
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hold every block input at a known value until the clocked processes take over.
    initial begin
        i_rst_n       = 0;
        in_ch.valid   = 0;
        in_ch.command = CMD_REGISTER;
        in_ch.key     = '0;
        in_ch.count   = '0;
        out_ch.ready  = 0;
    end

    // Driver: offer queued commands, wait out each one's gap, predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 0;
            tx_idle     <= 0;
        end else begin
            tx_accept = in_ch.valid && in_ch.ready;
            if (tx_accept) begin
                apply_command(in_ch.command, in_ch.key, in_ch.count);
                cmds_accepted++;
            end
            if (!in_ch.valid || tx_accept) begin
                tx_idle_eff = tx_accept ? 0 : tx_idle;
                if (cmd_queue.size() != 0 && tx_idle_eff >= cmd_queue[0].gap &&
                    (!cmd_queue[0].drain || expected_results.size() == 0)) begin
                    tx_item       = cmd_queue.pop_front();
                    in_ch.valid   <= 1;
                    in_ch.command <= tx_item.command;
                    in_ch.key     <= tx_item.key;
                    in_ch.count   <= tx_item.count;
                    tx_idle       <= 0;
                end else begin
                    in_ch.valid <= 0;
                    tx_idle     <= tx_idle_eff + 1;
                end
            end
        end
    end

    // Receiver: random wait after each transaction, burst stretches, and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            rx_gap       <= 0;
            rx_taken     <= 0;
            hold_left    <= 0;
            hold_done    <= 0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= (hold_left == 1);
        end else if (out_ch.valid && out_ch.ready) begin
            rx_taken <= rx_taken + 1;
            if (rx_taken + 1 == HOLD_AT && !hold_done) begin
                hold_done    <= 1;
                hold_left    <= HOLD_CYC;
                out_ch.ready <= 0;
            end else begin
                rx_draw      = (((rx_taken / 50) % 3) == 2) ? 0 : $urandom_range(0, GAP_MAX);
                rx_gap       <= rx_draw;
                out_ch.ready <= (rx_draw == 0);
            end
        end else if (rx_gap != 0) begin
            rx_gap       <= rx_gap - 1;
            out_ch.ready <= (rx_gap == 1);
        end else begin
            out_ch.ready <= 1;
        end
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d key_res %h granted %0d last %0d",
                       out_ch.status, out_ch.key_res, out_ch.granted, out_ch.last);
                fail_count++;
            end else begin
                mon_exp = expected_results.pop_front();
                if (out_ch.status !== mon_exp.status) begin
                    $error("status: expected %0d, actual %0d", mon_exp.status, out_ch.status);
                    fail_count++;
                end
                if (out_ch.key_res !== mon_exp.key_res) begin
                    $error("key_res: expected %h, actual %h", mon_exp.key_res, out_ch.key_res);
                    fail_count++;
                end
                if (out_ch.granted !== mon_exp.granted) begin
                    $error("granted: expected %0d, actual %0d", mon_exp.granted,
                           out_ch.granted);
                    fail_count++;
                end
                if (out_ch.last !== mon_exp.last) begin
                    $error("last: expected %0d, actual %0d", mon_exp.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_worker_registry_with_aging failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int r;
        int c;
        logic [KEY_W-1:0] k;
        logic [COUNT_W-1:0] n;
        cmds_accepted = 0;
        fail_count    = 0;
        stall_cycles  = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 0;
            slot_alive[i] = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++) worker_pool[i] = rand_key();

        // Directed: empty table, key extremes, heartbeat, bad count, unused code, aging,
        // a full table, then one request that drains all sixteen entries.
        gen_burst = 0;
        add_cmd(CMD_REQUEST, rand_key(), 8'd1, 0);
        add_cmd(CMD_REGISTER, {KEY_W{1'b1}}, 8'd0, 0);
        add_cmd(CMD_REGISTER, '0, {COUNT_W{1'b1}}, 0);
        add_cmd(CMD_REGISTER, {KEY_W{1'b1}}, 8'd7, 0);
        add_cmd(CMD_REQUEST, rand_key(), 8'd0, 0);
        add_cmd(CMD_UNUSED, rand_key(), 8'($urandom_range(0, 255)), 0);
        add_cmd(CMD_SWEEP, rand_key(), 8'd0, 0);
        add_cmd(CMD_REGISTER, '0, 8'd0, 0);
        add_cmd(CMD_SWEEP, rand_key(), 8'd128, 0);
        gen_burst = 1;
        for (int i = 0; i < ENTRIES - 1; i++) add_cmd(CMD_REGISTER, rand_key(), 8'd0, 0);
        gen_burst = 0;
        add_cmd(CMD_REGISTER, rand_key(), 8'd0, 0);
        add_cmd(CMD_REQUEST, rand_key(), {COUNT_W{1'b1}}, 0);

        // Random: mostly registers and heartbeats from a pool a bit larger than the table,
        // with requests, sweeps and the odd unused code mixed in. Drain twice midway.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            gen_burst = ((i / 30) % 3) == 1;
            r = $urandom_range(0, 99);
            n = 8'($urandom_range(0, 255));
            if (r < 70) begin
                k = ($urandom_range(0, 99) < 85) ? worker_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : rand_key();
                add_cmd(CMD_REGISTER, k, n, i == 70 || i == 140);
            end else if (r < 84) begin
                c = $urandom_range(0, 9);
                if (c == 0) n = '0;
                else if (c != 1) n = 8'($urandom_range(1, 4));
                add_cmd(CMD_REQUEST, rand_key(), n, i == 70 || i == 140);
            end else if (r < 95) begin
                add_cmd(CMD_SWEEP, rand_key(), n, i == 70 || i == 140);
            end else begin
                add_cmd(CMD_UNUSED, rand_key(), n, i == 70 || i == 140);
            end
        end
        cmds_total = cmd_queue.size();

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1;

        while (cmds_accepted != cmds_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_worker_registry_with_aging passed");
        end else begin
            $display("tb_worker_registry_with_aging failed");
        end
        $finish;
    end

endmodule
